@@ hw/rtl/sdi_pkg.sv @@
// Shared constants and types for the SIMP density interpolation pipeline.
package sdi_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int DENSITY_W  = 26;
   localparam int PEN_W      = 12;
   localparam int FLOOR_W    = 24;
   localparam int SF_W       = 25;
   localparam int SL_W       = 28;
   localparam int MF_W       = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [PEN_W-1:0]   PEN_MIN     = 12'd256;
   localparam logic [PEN_W-1:0]   PEN_MAX     = 12'd2048;
   localparam logic [PEN_W-1:0]   PEN_RESET   = 12'd768;
   localparam logic [FLOOR_W-1:0] EMIN_RESET  = 24'd17;
   localparam logic [FLOOR_W-1:0] MFLOOR_RESET = 24'd16777;

   // Fractional bits of the logarithm and number of series terms of the exponential.
   localparam int LOG_BITS    = 30;
   localparam int EXP_TERMS   = 16;
   localparam int RECIP_SHIFT = 34;
   localparam logic [31:0] LN2_Q32 = 32'd2977044471;

   localparam int LOG_LAT = LOG_BITS;
   localparam int EXP_LAT = 3 * EXP_TERMS;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PENALTY     = 2'd0,
      CSR_STIFF_FLOOR = 2'd1,
      CSR_MASS_FLOOR  = 2'd2,
      CSR_MASS_LAW    = 2'd3
   } csr_index_type;

endpackage

@@ hw/rtl/sdi_log2.sv @@
// Pipelined bit-serial log2 of a Q1.30 mantissa, one squaring stage per result bit.
module sdi_log2 (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [sdi_pkg::LOG_BITS:0]   mant,
   output logic [sdi_pkg::LOG_BITS-1:0] log_frac
);
   import sdi_pkg::*;

   logic [LOG_BITS:0]   m_ff  [LOG_BITS-1];
   logic [LOG_BITS-1:0] lm_ff [LOG_BITS];

   genvar j;
   generate
      for (j = 0; j < LOG_BITS; j++) begin : g_step
         logic [LOG_BITS:0]     m_prev;
         logic [LOG_BITS-1:0]   lm_prev;
         logic [2*LOG_BITS+1:0] sq;
         logic [LOG_BITS+1:0]   top_bits;
         logic [LOG_BITS-1:0]   lm_in;

         if (j == 0) begin : g_first
            assign m_prev  = mant;
            assign lm_prev = '0;
         end else begin : g_next
            assign m_prev  = m_ff[j-1];
            assign lm_prev = lm_ff[j-1];
         end

         assign sq       = (2*LOG_BITS+2)'(m_prev) * (2*LOG_BITS+2)'(m_prev);
         assign top_bits = sq[2*LOG_BITS+1:LOG_BITS];
         // A square at or above two yields a one bit and is halved back into [1,2).
         assign lm_in    = lm_prev | (top_bits[LOG_BITS+1] ?
                                      (LOG_BITS'(1) << (LOG_BITS-1-j)) : '0);

         always_ff @(posedge clock) begin
            if (advance) begin
               lm_ff[j] <= lm_in;
            end
         end

         if (j < LOG_BITS-1) begin : g_mant
            logic [LOG_BITS:0] m_in;
            assign m_in = top_bits[LOG_BITS+1] ? top_bits[LOG_BITS+1:1] : top_bits[LOG_BITS:0];
            always_ff @(posedge clock) begin
               if (advance) begin
                  m_ff[j] <= m_in;
               end
            end
         end
      end
   endgenerate

   assign log_frac = lm_ff[LOG_BITS-1];

endmodule

@@ hw/rtl/sdi_exp2.sv @@
// Pipelined 2^x for x in Q.30 within [0,1], by a truncated Taylor series in Q.32.
module sdi_exp2 (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [sdi_pkg::LOG_BITS:0] frac,
   output logic [31:0]               pow_val
);
   import sdi_pkg::*;

   logic [62:0] x_prod;
   logic [31:0] x0_ff;
   logic [31:0] xc_ff   [1:EXP_TERMS-1];
   logic [31:0] term_ff [1:EXP_TERMS-1];
   logic [33:0] sum_ff  [1:EXP_TERMS];
   logic [33:0] ev_in;
   logic [31:0] ev_ff;

   // Scale by ln 2 so that the e^x series yields 2^x.
   assign x_prod = 63'(frac) * 63'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff      <= x_prod[61:30];
         xc_ff[1]   <= x0_ff;
         term_ff[1] <= x0_ff;
         sum_ff[1]  <= (34'd1 << 32) + 34'(x0_ff);
      end
   end

   genvar n;
   generate
      for (n = 2; n <= EXP_TERMS; n++) begin : g_term
         localparam logic [33:0] RECIP = 34'((64'd1 << RECIP_SHIFT) / 64'(n));
         localparam logic [4:0]  DIV   = 5'(n);

         logic [63:0] prod_a;
         logic [31:0] va_ff;
         logic [33:0] suma_ff;
         logic [65:0] prod_b;
         logic [31:0] vb_ff;
         logic [31:0] qb_ff;
         logic [33:0] sumb_ff;
         logic [36:0] back;
         logic [36:0] rem;
         logic [31:0] q_in;

         assign prod_a = 64'(term_ff[n-1]) * 64'(xc_ff[n-1]);
         assign prod_b = 66'(va_ff) * 66'(RECIP);
         // The reciprocal estimate is low by at most one; one compare fixes it.
         assign back   = 37'(qb_ff) * 37'(DIV);
         assign rem    = 37'(vb_ff) - back;
         assign q_in   = (rem >= 37'(DIV)) ? qb_ff + 32'd1 : qb_ff;

         always_ff @(posedge clock) begin
            if (advance) begin
               va_ff     <= prod_a[63:32];
               suma_ff   <= sum_ff[n-1];
               vb_ff     <= va_ff;
               qb_ff     <= prod_b[65:34];
               sumb_ff   <= suma_ff;
               sum_ff[n] <= sumb_ff + 34'(q_in);
            end
         end

         if (n < EXP_TERMS) begin : g_pass
            logic [31:0] xa_ff;
            logic [31:0] xb_ff;
            always_ff @(posedge clock) begin
               if (advance) begin
                  xa_ff      <= xc_ff[n-1];
                  xb_ff      <= xa_ff;
                  xc_ff[n]   <= xb_ff;
                  term_ff[n] <= q_in;
               end
            end
         end
      end
   endgenerate

   assign ev_in = (sum_ff[EXP_TERMS] + 34'd2) >> 2;

   always_ff @(posedge clock) begin
      if (advance) begin
         ev_ff <= ev_in[31:0];
      end
   end

   assign pow_val = ev_ff;

endmodule

@@ hw/rtl/simp_density_interpolation.sv @@
// Modified SIMP interpolation: one density in, stiffness factor, its slope and mass factor out.
// The block takes one density per clock while the skid entry is free. The depth comes from
// the log2 unit, which spends one squaring stage on each of its 30 fractional bits, and from
// the two exp2 units (for r^p and r^(p-1)), which spend three stages on each of the 16 series
// terms; the rest is clamping, normalization, the exponent multiplies and the floor mixing.
// An output register with one skid entry lets the pipeline keep accepting while a result
// waits, and req_ready depends only on that skid entry. The user must write the registers
// only while idle; the block itself does not enforce this.
module simp_density_interpolation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sdi_pkg::DENSITY_W-1:0] req_density,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sdi_pkg::SF_W-1:0]          rsp_stiffness_factor,
   output logic [sdi_pkg::SL_W-1:0]          rsp_stiffness_slope,
   output logic [sdi_pkg::MF_W-1:0]          rsp_mass_factor,
   input  logic                              csr_write_en,
   input  logic [sdi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdi_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sdi_pkg::*;

   localparam int RW  = FRAC_BITS + 1;
   localparam int KW  = $clog2(FRAC_BITS + 1);
   localparam int LRW = KW + LOG_BITS;
   localparam int PW  = LRW + PEN_W;
   localparam int YW  = PW - 8;
   localparam int NW  = YW - LOG_BITS;
   localparam int SLW = RW + PEN_W;
   localparam logic [RW-1:0]   ONE      = RW'(1) << FRAC_BITS;
   localparam logic [31:0]     ONE_W    = 32'(1) << FRAC_BITS;
   localparam logic [2*RW-1:0] HALF     = (2*RW)'(1) << (FRAC_BITS - 1);
   localparam logic [NW-1:0]   BIG_N    = NW'(FRAC_BITS + 9);
   localparam logic [NW:0]     S_OFFSET = (NW+1)'(31 - FRAC_BITS);
   localparam logic [63:0]     SF_MAX   = (64'd1 << SF_W) - 64'd1;
   localparam logic [63:0]     SL_MAX   = (64'd1 << SL_W) - 64'd1;
   localparam logic [63:0]     MF_MAX   = (64'd1 << MF_W) - 64'd1;

   typedef struct packed {
      logic          vld;
      logic          zero;
      logic          one;
      logic [KW-1:0] k;
      logic [RW-1:0] r;
   } lside_type;

   typedef struct packed {
      logic          vld;
      logic          zero;
      logic          one;
      logic          e0;
      logic          big_p;
      logic          big_d;
      logic [5:0]    s_p;
      logic [5:0]    s_d;
      logic [RW-1:0] r;
   } eside_type;

   // Configuration registers and their saturated forms.
   logic [PEN_W-1:0]   penalty_ff;
   logic [FLOOR_W-1:0] emin_ff;
   logic [FLOOR_W-1:0] mfloor_ff;
   logic               law_ff;
   logic [PEN_W-1:0]   p_sat;
   logic [PEN_W-1:0]   p_dec;
   logic [RW-1:0]      emin_sat;
   logic [RW-1:0]      mfloor_sat;
   logic [RW-1:0]      emin_comp;
   logic [RW-1:0]      mfloor_comp;

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff <= PEN_RESET;
         emin_ff    <= EMIN_RESET;
         mfloor_ff  <= MFLOOR_RESET;
         law_ff     <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PENALTY:     penalty_ff <= csr_data[PEN_W-1:0];
            CSR_STIFF_FLOOR: emin_ff    <= csr_data[FLOOR_W-1:0];
            CSR_MASS_FLOOR:  mfloor_ff  <= csr_data[FLOOR_W-1:0];
            CSR_MASS_LAW:    law_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign p_sat       = (penalty_ff < PEN_MIN) ? PEN_MIN :
                        ((penalty_ff > PEN_MAX) ? PEN_MAX : penalty_ff);
   assign p_dec       = p_sat - PEN_MIN;
   assign emin_sat    = (32'(emin_ff) > ONE_W) ? ONE : RW'(emin_ff);
   assign mfloor_sat  = (32'(mfloor_ff) > ONE_W) ? ONE : RW'(mfloor_ff);
   assign emin_comp   = ONE - emin_sat;
   assign mfloor_comp = ONE - mfloor_sat;

   // Flow control: the whole pipeline moves unless the skid entry is occupied.
   logic advance;
   logic out_vld_ff;
   logic skid_vld_ff;

   assign advance   = !skid_vld_ff;
   assign req_ready = advance;

   // Stage 1: clamp the density to [0, one].
   logic [31:0]   dens_mag;
   logic [RW-1:0] s1_r_in;
   logic [RW-1:0] s1_r_ff;
   logic          s1_vld_ff;

   assign dens_mag = 32'(req_density[DENSITY_W-2:0]);
   assign s1_r_in  = req_density[DENSITY_W-1] ? '0 :
                     ((dens_mag > ONE_W) ? ONE : RW'(dens_mag));

   // Stage 2: leading one of r.
   logic [KW-1:0] lead_pos;
   lside_type     s2_in;
   lside_type     s2_ff;

   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (s1_r_ff[i]) begin
            lead_pos = KW'(i);
         end
      end
   end

   assign s2_in.vld  = s1_vld_ff;
   assign s2_in.zero = (s1_r_ff == '0);
   assign s2_in.one  = s1_r_ff[FRAC_BITS];
   assign s2_in.k    = KW'(FRAC_BITS) - lead_pos;
   assign s2_in.r    = s1_r_ff;

   // Stage 3: normalize r into a Q1.30 mantissa.
   logic [4:0]        norm_shift;
   logic [LOG_BITS:0] s3_m_in;
   logic [LOG_BITS:0] s3_m_ff;
   lside_type         s3_ff;

   assign norm_shift = 5'(LOG_BITS - FRAC_BITS) + 5'(s2_ff.k);
   assign s3_m_in    = (LOG_BITS+1)'(s2_ff.r[FRAC_BITS-1:0]) << norm_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_ff.vld <= s2_in.vld;
         s3_ff.vld <= s2_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_r_ff    <= s1_r_in;
         s2_ff.zero <= s2_in.zero;
         s2_ff.one  <= s2_in.one;
         s2_ff.k    <= s2_in.k;
         s2_ff.r    <= s2_in.r;
         s3_ff.zero <= s2_ff.zero;
         s3_ff.one  <= s2_ff.one;
         s3_ff.k    <= s2_ff.k;
         s3_ff.r    <= s2_ff.r;
         s3_m_ff    <= s3_m_in;
      end
   end

   // Logarithm of the mantissa, with the item's side data delayed alongside.
   logic [LOG_BITS-1:0] log_frac;
   lside_type           lside_ff [LOG_LAT];

   sdi_log2 u_log2 (
      .clock    (clock),
      .advance  (advance),
      .mant     (s3_m_ff),
      .log_frac (log_frac)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOG_LAT; i++) begin
            lside_ff[i] <= '0;
         end
      end else if (advance) begin
         lside_ff[0] <= s3_ff;
         for (int i = 1; i < LOG_LAT; i++) begin
            lside_ff[i] <= lside_ff[i-1];
         end
      end
   end

   // Stage Y1: -log2 r in Q.30.
   lside_type      y1_ff;
   logic [LRW-1:0] y1_lr_in;
   logic [LRW-1:0] y1_lr_ff;

   assign y1_lr_in = (LRW'(lside_ff[LOG_LAT-1].k) << LOG_BITS) - LRW'(log_frac);

   // Stage Y2: scale by both exponents.
   lside_type     y2_ff;
   logic [PW-1:0] y2_prod_p_ff;
   logic [PW-1:0] y2_prod_d_ff;

   // Stage Y3: split into integer and fraction, derive the final shift.
   logic [YW-1:0]       y_p;
   logic [YW-1:0]       y_d;
   logic [NW-1:0]       n_p;
   logic [NW-1:0]       n_d;
   logic [NW:0]         s_full_p;
   logic [NW:0]         s_full_d;
   logic [LOG_BITS:0]   fr_p_in;
   logic [LOG_BITS:0]   fr_d_in;
   logic [LOG_BITS:0]   y3_fr_p_ff;
   logic [LOG_BITS:0]   y3_fr_d_ff;
   eside_type           y3_in;
   eside_type           y3_ff;
   logic [PW-1:0]       rnd_p;
   logic [PW-1:0]       rnd_d;

   assign rnd_p    = y2_prod_p_ff + PW'(128);
   assign rnd_d    = y2_prod_d_ff + PW'(128);
   assign y_p      = rnd_p[PW-1:8];
   assign y_d      = rnd_d[PW-1:8];
   assign n_p      = y_p[YW-1:LOG_BITS];
   assign n_d      = y_d[YW-1:LOG_BITS];
   assign fr_p_in  = ((LOG_BITS+1)'(1) << LOG_BITS) - (LOG_BITS+1)'(y_p[LOG_BITS-1:0]);
   assign fr_d_in  = ((LOG_BITS+1)'(1) << LOG_BITS) - (LOG_BITS+1)'(y_d[LOG_BITS-1:0]);
   assign s_full_p = (NW+1)'(n_p) + S_OFFSET;
   assign s_full_d = (NW+1)'(n_d) + S_OFFSET;

   assign y3_in.vld   = y2_ff.vld;
   assign y3_in.zero  = y2_ff.zero;
   assign y3_in.one   = y2_ff.one;
   assign y3_in.e0    = (p_sat == PEN_MIN);
   assign y3_in.big_p = (n_p >= BIG_N);
   assign y3_in.big_d = (n_d >= BIG_N);
   assign y3_in.s_p   = s_full_p[5:0];
   assign y3_in.s_d   = s_full_d[5:0];
   assign y3_in.r     = y2_ff.r;

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff.vld <= 1'b0;
         y2_ff.vld <= 1'b0;
         y3_ff.vld <= 1'b0;
      end else if (advance) begin
         y1_ff.vld <= lside_ff[LOG_LAT-1].vld;
         y2_ff.vld <= y1_ff.vld;
         y3_ff.vld <= y3_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y1_ff.zero   <= lside_ff[LOG_LAT-1].zero;
         y1_ff.one    <= lside_ff[LOG_LAT-1].one;
         y1_ff.k      <= lside_ff[LOG_LAT-1].k;
         y1_ff.r      <= lside_ff[LOG_LAT-1].r;
         y1_lr_ff     <= y1_lr_in;
         y2_ff.zero   <= y1_ff.zero;
         y2_ff.one    <= y1_ff.one;
         y2_ff.k      <= y1_ff.k;
         y2_ff.r      <= y1_ff.r;
         y2_prod_p_ff <= PW'(y1_lr_ff) * PW'(p_sat);
         y2_prod_d_ff <= PW'(y1_lr_ff) * PW'(p_dec);
         y3_ff.zero   <= y3_in.zero;
         y3_ff.one    <= y3_in.one;
         y3_ff.e0     <= y3_in.e0;
         y3_ff.big_p  <= y3_in.big_p;
         y3_ff.big_d  <= y3_in.big_d;
         y3_ff.s_p    <= y3_in.s_p;
         y3_ff.s_d    <= y3_in.s_d;
         y3_ff.r      <= y3_in.r;
         y3_fr_p_ff   <= fr_p_in;
         y3_fr_d_ff   <= fr_d_in;
      end
   end

   // Exponentials for r^p and r^(p-1).
   logic [31:0] ev_p;
   logic [31:0] ev_d;
   eside_type   eside_ff [EXP_LAT];

   sdi_exp2 u_exp2_p (
      .clock   (clock),
      .advance (advance),
      .frac    (y3_fr_p_ff),
      .pow_val (ev_p)
   );

   sdi_exp2 u_exp2_d (
      .clock   (clock),
      .advance (advance),
      .frac    (y3_fr_d_ff),
      .pow_val (ev_d)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EXP_LAT; i++) begin
            eside_ff[i] <= '0;
         end
      end else if (advance) begin
         eside_ff[0] <= y3_ff;
         for (int i = 1; i < EXP_LAT; i++) begin
            eside_ff[i] <= eside_ff[i-1];
         end
      end
   end

   // Stage F1: final rounding shift and the special cases of the power.
   function automatic logic [RW-1:0] pow_pick(
      input logic        e0,
      input logic        zero,
      input logic        one,
      input logic        big,
      input logic [5:0]  sh,
      input logic [31:0] ev
   );
      logic [32:0] rnd;
      begin
         rnd = ({1'b0, ev} + (33'd1 << (sh - 6'd1))) >> sh;
         if (e0 || (one && !zero)) begin
            pow_pick = ONE;
         end else if (zero || big) begin
            pow_pick = '0;
         end else begin
            pow_pick = RW'(rnd);
         end
      end
   endfunction

   eside_type     es;
   logic [RW-1:0] f1_pp_in;
   logic [RW-1:0] f1_pd_in;
   logic          f1_vld_ff;
   logic [RW-1:0] f1_pp_ff;
   logic [RW-1:0] f1_pd_ff;
   logic [RW-1:0] f1_r_ff;

   assign es       = eside_ff[EXP_LAT-1];
   assign f1_pp_in = pow_pick(1'b0, es.zero, es.one, es.big_p, es.s_p, ev_p);
   assign f1_pd_in = pow_pick(es.e0, es.zero, es.one, es.big_d, es.s_d, ev_d);

   // Stage F2: products with the floor complements.
   logic            f2_vld_ff;
   logic [2*RW-1:0] f2_sfp_ff;
   logic [2*RW-1:0] f2_tp_ff;
   logic [2*RW-1:0] f2_mp_ff;
   logic [RW-1:0]   f2_r_ff;

   // Stage F3: rounding, floor addition and the choice of mass law.
   logic [2*RW-1:0] sf_rnd;
   logic [2*RW-1:0] t_rnd;
   logic [2*RW-1:0] mp_rnd;
   logic [RW:0]     f3_sf_in;
   logic [RW:0]     f3_mass_in;
   logic            f3_vld_ff;
   logic [RW:0]     f3_sf_ff;
   logic [RW-1:0]   f3_t_ff;
   logic [RW:0]     f3_mass_ff;

   assign sf_rnd     = (f2_sfp_ff + HALF) >> FRAC_BITS;
   assign t_rnd      = (f2_tp_ff + HALF) >> FRAC_BITS;
   assign mp_rnd     = (f2_mp_ff + HALF) >> FRAC_BITS;
   assign f3_sf_in   = (RW+1)'(emin_sat) + (RW+1)'(sf_rnd);
   assign f3_mass_in = law_ff ? (RW+1)'(mfloor_sat) + (RW+1)'(mp_rnd) : (RW+1)'(f2_r_ff);

   // Stage F4: slope product.
   logic           f4_vld_ff;
   logic [SLW-1:0] f4_slp_ff;
   logic [RW:0]    f4_sf_ff;
   logic [RW:0]    f4_mass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (advance) begin
         f1_vld_ff <= es.vld;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_pp_ff   <= f1_pp_in;
         f1_pd_ff   <= f1_pd_in;
         f1_r_ff    <= es.r;
         f2_sfp_ff  <= (2*RW)'(emin_comp) * (2*RW)'(f1_pp_ff);
         f2_tp_ff   <= (2*RW)'(emin_comp) * (2*RW)'(f1_pd_ff);
         f2_mp_ff   <= (2*RW)'(mfloor_comp) * (2*RW)'(f1_pp_ff);
         f2_r_ff    <= f1_r_ff;
         f3_sf_ff   <= f3_sf_in;
         f3_t_ff    <= t_rnd[RW-1:0];
         f3_mass_ff <= f3_mass_in;
         f4_slp_ff  <= SLW'(f3_t_ff) * SLW'(p_sat);
         f4_sf_ff   <= f3_sf_ff;
         f4_mass_ff <= f3_mass_ff;
      end
   end

   // Slope rounding and saturation of all three fields.
   logic [SLW-1:0] slope_rnd;
   logic [SF_W-1:0] pipe_sf;
   logic [SL_W-1:0] pipe_sl;
   logic [MF_W-1:0] pipe_mf;

   assign slope_rnd = (f4_slp_ff + SLW'(128)) >> 8;
   assign pipe_sf   = (64'(f4_sf_ff) > SF_MAX) ? SF_MAX[SF_W-1:0] : SF_W'(f4_sf_ff);
   assign pipe_sl   = (64'(slope_rnd) > SL_MAX) ? SL_MAX[SL_W-1:0] : SL_W'(slope_rnd);
   assign pipe_mf   = (64'(f4_mass_ff) > MF_MAX) ? MF_MAX[MF_W-1:0] : MF_W'(f4_mass_ff);

   // Output register with one skid entry.
   logic [SF_W-1:0] out_sf_ff;
   logic [SL_W-1:0] out_sl_ff;
   logic [MF_W-1:0] out_mf_ff;
   logic [SF_W-1:0] skid_sf_ff;
   logic [SL_W-1:0] skid_sl_ff;
   logic [MF_W-1:0] skid_mf_ff;
   logic            out_load;
   logic            skid_load;

   assign out_load  = !out_vld_ff || rsp_ready;
   assign skid_load = !out_load && f4_vld_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff  <= skid_vld_ff || f4_vld_ff;
         skid_vld_ff <= 1'b0;
      end else if (skid_load) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (skid_vld_ff) begin
            out_sf_ff <= skid_sf_ff;
            out_sl_ff <= skid_sl_ff;
            out_mf_ff <= skid_mf_ff;
         end else begin
            out_sf_ff <= pipe_sf;
            out_sl_ff <= pipe_sl;
            out_mf_ff <= pipe_mf;
         end
      end
      if (skid_load) begin
         skid_sf_ff <= pipe_sf;
         skid_sl_ff <= pipe_sl;
         skid_mf_ff <= pipe_mf;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_stiffness_factor = out_sf_ff;
   assign rsp_stiffness_slope  = out_sl_ff;
   assign rsp_mass_factor      = out_mf_ff;

endmodule

@@ hw/rtl/sdi_port_checker.sv @@
// Port-level assertions for the SIMP density interpolation block, bound to its top level.
module sdi_port_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [sdi_pkg::SF_W-1:0] rsp_stiffness_factor,
   input logic [sdi_pkg::SL_W-1:0] rsp_stiffness_slope,
   input logic [sdi_pkg::MF_W-1:0] rsp_mass_factor
);
   import sdi_pkg::*;

   // A stalled result keeps its fields until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stiffness_factor) &&
      $stable(rsp_stiffness_slope) && $stable(rsp_mass_factor))
      else $error("result changed while stalled");

   // Reset empties the output stage.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented right after reset");

   // Input back-pressure only arises behind a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // A result transfer always frees the skid entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("input still stalled after a result transfer");

   // A request refused for want of ready is still valid in the cycle after.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before transfer");

endmodule

bind simp_density_interpolation sdi_port_checker u_port_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_stiffness_factor (rsp_stiffness_factor),
   .rsp_stiffness_slope  (rsp_stiffness_slope),
   .rsp_mass_factor      (rsp_mass_factor)
);
